>>> hdl/lth_pkg.sv
`default_nettype none
package lth_pkg;

    localparam int LAYERS      = 64;
    localparam int SLOT_W      = 6;
    localparam int CNT_W       = 32;
    localparam int ADDR_W      = 2 * SLOT_W;
    localparam int ID_W        = 24;
    localparam int R_W         = 19;
    localparam int Z_W         = 20;
    localparam int CMP_W       = 22;
    localparam int TOLERANCE   = 32;
    localparam int THR_W       = 17;
    localparam int PROD_W      = CNT_W + THR_W;
    localparam int LIU_W       = 7;
    localparam int IN_DATA_W   = 160;
    localparam int OUT_DATA_W  = 96;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_HIT   = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [0:0] REG_LAYERS = 1'b0;
    localparam logic [0:0] REG_THRESH = 1'b1;

    // One classified item handed from the front to the back.
    typedef struct packed {
        logic [1:0]        kind;
        logic              found;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   id;
        logic              last;
        logic [SLOT_W-1:0] from_slot;
        logic [SLOT_W-1:0] to_slot;
    } t_task;

    typedef struct packed {
        logic [1:0]       kind;
        logic             hit_matched;
        logic [ID_W-1:0]  matched_id;
        logic             same_layer_skip;
        logic [CNT_W-1:0] pair_count;
        logic             passes_cut;
        logic             no_tracks;
        logic [CNT_W-1:0] tracks_total;
    } t_result;

endpackage
`default_nettype wire

>>> hdl/layer_transition_histogram_top.sv
`default_nettype none
// Layer transition histogram.
// Input stream s_*: s_tuser carries the command (load, hit, query), s_tlast marks
// a track's last hit, s_tdata carries the window, hit and query fields.
// Output stream m_*: one result item per input item, in order; m_tuser echoes
// the command and m_tdata carries the result fields.
// Registers on the APB port: layers_in_use at 0x0, prob_threshold at 0x4.
// A front stage latches the item, compares a hit against the widened windows of
// the layers in use (up to 64) in parallel and priority-encodes the first match;
// loads and queries go straight to its push state, hits pass through compare and
// encode states first. A two-entry queue decouples it from the back stage, which
// pops an item only when idle, reading the pair count memory, and does the write
// of the read-modify-write in its execute state before it takes the next item.
// After reset the 4096-entry pair memory is cleared one entry per cycle, so
// s_tready stays low until the clearing pass ends; register writes are taken meanwhile.
// When the receiver stalls, the result register holds, the queue fills and the
// front then holds s_tready low.
module layer_transition_histogram_top (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // entry_index, min_r, max_r, min_z, max_z, layer_id, coord_r, coord_z,
    // from_layer, to_layer, zero pad
    input  wire logic [159:0] s_tdata,
    input  wire logic [1:0]   s_tuser,   // cmd
    input  wire logic         s_tlast,   // last_hit
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // hit_matched, matched_id, same_layer_skip, pair_count, passes_cut,
    // no_tracks, tracks_total, zero pad
    output logic [95:0]       m_tdata,
    output logic [1:0]        m_tuser,   // result_kind
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [lth_pkg::LIU_W-1:0] r_layers;
    logic [lth_pkg::THR_W-1:0] r_thresh;

    logic             clearing, full, empty, push, pop, ovalid;
    lth_pkg::t_task   f_task, q_task;
    lth_pkg::t_result res;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == lth_pkg::REG_THRESH) ? {15'h0, r_thresh} : {25'h0, r_layers};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layers <= '0;
            r_thresh <= '0;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == lth_pkg::REG_LAYERS) begin
                r_layers <= pwdata[lth_pkg::LIU_W-1:0];
            end else begin
                r_thresh <= pwdata[lth_pkg::THR_W-1:0];
            end
        end
    end

    lth_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clearing (clearing),
        .i_layers   (r_layers),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_s_tlast  (s_tlast),
        .i_full     (full),
        .o_push     (push),
        .o_task     (f_task)
    );

    lth_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_task  (f_task),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_task  (q_task)
    );

    lth_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_thresh   (r_thresh),
        .o_clearing (clearing),
        .i_empty    (empty),
        .i_task     (q_task),
        .o_pop      (pop),
        .o_valid    (ovalid),
        .i_ready    (m_tready),
        .o_result   (res)
    );

    assign m_tvalid = ovalid;
    assign m_tuser  = res.kind;
    assign m_tdata  = {4'h0, res.tracks_total, res.no_tracks, res.passes_cut,
                       res.pair_count, res.same_layer_skip, res.matched_id, res.hit_matched};

endmodule
`default_nettype wire

>>> hdl/lth_front.sv
`default_nettype none
module lth_front (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_clearing,
    input  wire logic [lth_pkg::LIU_W-1:0]            i_layers,
    input  wire logic                                 i_s_tvalid,
    output logic                                      o_s_tready,
    input  wire logic [lth_pkg::IN_DATA_W-1:0]        i_s_tdata,
    input  wire logic [1:0]                           i_s_tuser,
    input  wire logic                                 i_s_tlast,
    input  wire logic                                 i_full,
    output logic                                      o_push,
    output lth_pkg::t_task                            o_task
);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_CMP  = 4'b0010,
        F_ENC  = 4'b0100,
        F_PUSH = 4'b1000
    } t_fstate;

    t_fstate r_state, n_state;

    logic [lth_pkg::R_W-1:0]   r_rmin [lth_pkg::LAYERS];
    logic [lth_pkg::R_W-1:0]   r_rmax [lth_pkg::LAYERS];
    logic [lth_pkg::Z_W-1:0]   r_zmin [lth_pkg::LAYERS];
    logic [lth_pkg::Z_W-1:0]   r_zmax [lth_pkg::LAYERS];
    logic [lth_pkg::ID_W-1:0]  r_idmem [lth_pkg::LAYERS];

    logic [lth_pkg::R_W-1:0]    r_cr;
    logic [lth_pkg::Z_W-1:0]    r_cz;
    logic [lth_pkg::LAYERS-1:0] r_vec;
    lth_pkg::t_task             r_task;

    logic                       accept;
    logic [lth_pkg::LAYERS-1:0] n_vec;
    logic [lth_pkg::SLOT_W-1:0] enc_slot;
    logic                       enc_found;
    logic [lth_pkg::LIU_W-1:0]  n_lim;

    logic [lth_pkg::SLOT_W-1:0] in_entry;
    logic [lth_pkg::R_W-1:0]    in_min_r, in_max_r, in_cr;
    logic [lth_pkg::Z_W-1:0]    in_min_z, in_max_z, in_cz;
    logic [lth_pkg::ID_W-1:0]   in_id;
    logic [lth_pkg::SLOT_W-1:0] in_from, in_to;

    assign in_entry = i_s_tdata[5:0];
    assign in_min_r = i_s_tdata[24:6];
    assign in_max_r = i_s_tdata[43:25];
    assign in_min_z = i_s_tdata[63:44];
    assign in_max_z = i_s_tdata[83:64];
    assign in_id    = i_s_tdata[107:84];
    assign in_cr    = i_s_tdata[126:108];
    assign in_cz    = i_s_tdata[146:127];
    assign in_from  = i_s_tdata[152:147];
    assign in_to    = i_s_tdata[158:153];

    assign o_s_tready = (r_state == F_IDLE) && !i_clearing;
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_push     = (r_state == F_PUSH) && !i_full;
    assign o_task     = r_task;

    assign n_lim = (i_layers > lth_pkg::LIU_W'(lth_pkg::LAYERS))
                 ? lth_pkg::LIU_W'(lth_pkg::LAYERS) : i_layers;

    // Every lane compares the hit against its own widened window.
    always_comb begin
        logic signed [lth_pkg::CMP_W-1:0] z, r, zl, zh, rl, rh;
        z = lth_pkg::CMP_W'($signed(r_cz));
        r = $signed({3'b000, r_cr});
        for (int i = 0; i < lth_pkg::LAYERS; i++) begin
            zl = lth_pkg::CMP_W'($signed(r_zmin[i])) - lth_pkg::CMP_W'(lth_pkg::TOLERANCE);
            zh = lth_pkg::CMP_W'($signed(r_zmax[i])) + lth_pkg::CMP_W'(lth_pkg::TOLERANCE);
            rl = $signed({3'b000, r_rmin[i]}) - lth_pkg::CMP_W'(lth_pkg::TOLERANCE);
            rh = $signed({3'b000, r_rmax[i]}) + lth_pkg::CMP_W'(lth_pkg::TOLERANCE);
            n_vec[i] = (lth_pkg::LIU_W'(i) < n_lim) && (zl <= z) && (z <= zh)
                       && (rl <= r) && (r <= rh);
        end
    end

    always_comb begin
        enc_slot  = '0;
        enc_found = |r_vec;
        for (int i = lth_pkg::LAYERS - 1; i >= 0; i--) begin
            if (r_vec[i]) begin
                enc_slot = lth_pkg::SLOT_W'(i);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (accept) begin
                    n_state = (i_s_tuser == lth_pkg::CMD_HIT) ? F_CMP : F_PUSH;
                end
            end
            F_CMP:  n_state = F_ENC;
            F_ENC:  n_state = F_PUSH;
            F_PUSH: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_s_tuser == lth_pkg::CMD_LOAD) begin
            r_rmin[in_entry]  <= in_min_r;
            r_rmax[in_entry]  <= in_max_r;
            r_zmin[in_entry]  <= in_min_z;
            r_zmax[in_entry]  <= in_max_z;
            r_idmem[in_entry] <= in_id;
        end
        if (accept) begin
            r_cr             <= in_cr;
            r_cz             <= in_cz;
            r_task.kind      <= i_s_tuser;
            r_task.last      <= i_s_tlast;
            r_task.from_slot <= in_from;
            r_task.to_slot   <= in_to;
            r_task.found     <= 1'b0;
            r_task.slot      <= '0;
            r_task.id        <= '0;
        end
        if (r_state == F_CMP) begin
            r_vec <= n_vec;
        end
        if (r_state == F_ENC) begin
            r_task.found <= enc_found;
            r_task.slot  <= enc_slot;
            r_task.id    <= enc_found ? r_idmem[enc_slot] : '0;
        end
    end

endmodule
`default_nettype wire

>>> hdl/lth_queue.sv
`default_nettype none
module lth_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire lth_pkg::t_task i_task,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_empty,
    output lth_pkg::t_task      o_task
);

    lth_pkg::t_task r_mem [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_task  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_task;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule
`default_nettype wire

>>> hdl/lth_back.sv
`default_nettype none
module lth_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [lth_pkg::THR_W-1:0]     i_thresh,
    output logic                               o_clearing,
    input  wire logic                          i_empty,
    input  wire lth_pkg::t_task                i_task,
    output logic                               o_pop,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output lth_pkg::t_result                   o_result
);

    typedef enum logic [2:0] {
        B_CLEAR = 3'b001,
        B_IDLE  = 3'b010,
        B_EXEC  = 3'b100
    } t_bstate;

    t_bstate r_state, n_state;

    logic [lth_pkg::CNT_W-1:0]  r_mem [1 << lth_pkg::ADDR_W];
    logic [lth_pkg::CNT_W-1:0]  r_rdata;
    logic [lth_pkg::ADDR_W-1:0] r_clr, r_addr;
    logic                       r_inc;

    logic [lth_pkg::CNT_W-1:0]  r_total;
    logic [lth_pkg::SLOT_W-1:0] r_prev;
    logic                       r_prev_ok;
    logic [1:0]                 r_hits;
    logic [lth_pkg::PROD_W-1:0] r_prod;

    lth_pkg::t_task             r_cur;
    logic                       r_skip;
    logic                       r_ovalid;
    lth_pkg::t_result           r_out;

    logic                       pop_ok;
    logic [lth_pkg::ADDR_W-1:0] addr;
    logic                       inc;
    logic                       skip;
    logic [1:0]                 hits_n;
    logic                       mem_we;
    logic [lth_pkg::ADDR_W-1:0] mem_wa;
    logic [lth_pkg::CNT_W-1:0]  mem_wd;
    logic [lth_pkg::CNT_W-1:0]  sat_rd;

    assign o_clearing = (r_state == B_CLEAR);
    assign pop_ok     = (r_state == B_IDLE) && !i_empty && (!r_ovalid || i_ready);
    assign o_pop      = pop_ok;
    assign o_valid    = r_ovalid;
    assign o_result   = r_out;

    assign hits_n = (r_hits == 2'd3) ? 2'd3 : r_hits + 2'd1;
    assign skip   = i_task.found && r_prev_ok && (r_prev == i_task.slot);
    assign inc    = (i_task.kind == lth_pkg::CMD_HIT) && i_task.found && r_prev_ok
                    && (r_prev != i_task.slot);
    assign addr   = (i_task.kind == lth_pkg::CMD_HIT) ? {r_prev, i_task.slot}
                                                      : {i_task.from_slot, i_task.to_slot};
    assign sat_rd = (&r_rdata) ? r_rdata : r_rdata + 1'b1;

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_clr;
        mem_wd = '0;
        if (r_state == B_CLEAR) begin
            mem_we = 1'b1;
        end else if (r_state == B_EXEC && r_inc) begin
            mem_we = 1'b1;
            mem_wa = r_addr;
            mem_wd = sat_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_mem[addr];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_CLEAR: begin
                if (&r_clr) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (pop_ok) begin
                    n_state = B_EXEC;
                end
            end
            B_EXEC:  n_state = B_IDLE;
            default: n_state = B_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_CLEAR;
            r_clr     <= '0;
            r_total   <= '0;
            r_prev    <= '0;
            r_prev_ok <= 1'b0;
            r_hits    <= 2'd0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (pop_ok && i_task.kind == lth_pkg::CMD_HIT) begin
                if (i_task.last) begin
                    if (hits_n >= 2'd2 && !(&r_total)) begin
                        r_total <= r_total + 1'b1;
                    end
                    r_hits    <= 2'd0;
                    r_prev_ok <= 1'b0;
                    r_prev    <= '0;
                end else begin
                    r_hits <= hits_n;
                    if (i_task.found) begin
                        r_prev    <= i_task.slot;
                        r_prev_ok <= 1'b1;
                    end
                end
            end
            if (r_state == B_EXEC) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // The product is a register that follows the total in the next cycle, before any query can use it.
    always_ff @(posedge i_clk) begin
        r_prod <= lth_pkg::PROD_W'(r_total) * lth_pkg::PROD_W'(i_thresh);
        if (pop_ok) begin
            r_cur  <= i_task;
            r_addr <= addr;
            r_inc  <= inc;
            r_skip <= skip;
        end
        if (r_state == B_EXEC) begin
            r_out.kind            <= r_cur.kind;
            r_out.hit_matched     <= (r_cur.kind == lth_pkg::CMD_HIT) && r_cur.found;
            r_out.matched_id      <= (r_cur.kind == lth_pkg::CMD_HIT) ? r_cur.id : '0;
            r_out.same_layer_skip <= (r_cur.kind == lth_pkg::CMD_HIT) && r_skip;
            r_out.pair_count      <= (r_cur.kind == lth_pkg::CMD_QUERY) ? r_rdata : '0;
            r_out.no_tracks       <= (r_cur.kind == lth_pkg::CMD_QUERY) && (r_total == '0);
            r_out.passes_cut      <= (r_cur.kind == lth_pkg::CMD_QUERY) && (r_total != '0)
                                     && ({1'b0, r_rdata, 16'h0000} > r_prod);
            r_out.tracks_total    <= r_total;
        end
    end

`ifndef SYNTHESIS
    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_CLEAR) |-> !o_pop) else $error("pop during clearing pass");
    a_pop_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == B_EXEC)) else $error("pop not followed by execute");
    a_total_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_total >= $past(r_total))) else $error("track total decreased");
    a_cut_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> !(r_out.no_tracks && r_out.passes_cut)) else $error("cut without tracks");
`endif

endmodule
`default_nettype wire
